// ===== rtl/vumn_pkg.sv =====
// Shared types, constants and tick tables of the VU needle with peak hold.
package vumn_pkg;

    localparam int TICK_COUNT = 12;
    localparam int TICK_IW    = $clog2(TICK_COUNT);
    localparam int LEVEL_W    = 24;
    localparam int MAG_W      = LEVEL_W - 1;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int DFR_W      = 9;
    localparam int HOLD_W     = 16;
    localparam int POS_W      = 8;
    localparam int FRAME_W    = 8;
    localparam int THR_W      = 32;
    localparam int Q_BITS     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] FULL_POS = POS_W'(129);

    localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(4096);
    localparam logic [DFR_W-1:0]  DFR_RST   = DFR_W'(128);
    localparam logic [HOLD_W-1:0] HOLD_RST  = HOLD_W'(30);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_GAIN     = 2'd0,
        REG_DISPLAY_FRAMES = 2'd1,
        REG_HOLD_UPDATES   = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_SCAN,
        S_SEG,
        S_SEG_GO,
        S_MUL_S,
        S_DIV_S,
        S_FRM_GO,
        S_MUL_F,
        S_DIV_F,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // Tick thresholds, unsigned Q0.32.
    function automatic logic [THR_W-1:0] tick_amp(input logic [TICK_IW-1:0] idx);
        logic [THR_W-1:0] a;
        case (idx)
            TICK_IW'(0):  a = 32'd38633126;
            TICK_IW'(1):  a = 32'd122168673;
            TICK_IW'(2):  a = 32'd172567838;
            TICK_IW'(3):  a = 32'd217250034;
            TICK_IW'(4):  a = 32'd273501591;
            TICK_IW'(5):  a = 32'd306873831;
            TICK_IW'(6):  a = 32'd344318102;
            TICK_IW'(7):  a = 32'd386331265;
            TICK_IW'(8):  a = 32'd433470809;
            TICK_IW'(9):  a = 32'd486362247;
            TICK_IW'(10): a = 32'd545707417;
            TICK_IW'(11): a = 32'd578042614;
            default:      a = '0;
        endcase
        return a;
    endfunction

    // Needle positions at the ticks.
    function automatic logic [POS_W-1:0] tick_pos(input logic [TICK_IW-1:0] idx);
        logic [POS_W-1:0] p;
        case (idx)
            TICK_IW'(0):  p = 8'd4;
            TICK_IW'(1):  p = 8'd21;
            TICK_IW'(2):  p = 8'd32;
            TICK_IW'(3):  p = 8'd42;
            TICK_IW'(4):  p = 8'd56;
            TICK_IW'(5):  p = 8'd65;
            TICK_IW'(6):  p = 8'd74;
            TICK_IW'(7):  p = 8'd84;
            TICK_IW'(8):  p = 8'd97;
            TICK_IW'(9):  p = 8'd109;
            TICK_IW'(10): p = 8'd123;
            TICK_IW'(11): p = 8'd129;
            default:      p = '0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/vumn_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module vumn_mul #(
    parameter int AW = 40,
    parameter int BW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [AW-1:0]            i_a,
    input  logic [BW-1:0]            i_b,
    input  logic [$clog2(BW+1)-1:0]  i_nbits,
    output vumn_pkg::t_unit_stat     o_stat,
    output logic [AW+BW-1:0]         o_product
);
    import vumn_pkg::*;

    localparam int PW   = AW + BW;
    localparam int CNTW = $clog2(BW + 1);

    logic [PW-1:0]   r_acc;
    logic [PW-1:0]   r_a;
    logic [BW-1:0]   r_b;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Add the shifted multiplicand for each set multiplier bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= PW'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_acc;

endmodule

// ===== rtl/vumn_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient known to fit Q_BITS.
module vumn_div #(
    parameter int NW = 42,
    parameter int DW = 34
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [NW-1:0]                 i_num,
    input  logic [DW-1:0]                 i_den,
    output vumn_pkg::t_unit_stat          o_stat,
    output logic [vumn_pkg::Q_BITS-1:0]   o_quot
);
    import vumn_pkg::*;

    localparam int CNTW = $clog2(Q_BITS + 1);

    logic [NW-1:0]     r_rem;
    logic [NW-1:0]     r_dsr;
    logic [Q_BITS-1:0] r_q;
    logic [CNTW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              ge;

    assign ge = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(Q_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Try the divisor at each weight from the top quotient bit down.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsr <= NW'(i_den) << (Q_BITS - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_q   <= {r_q[Q_BITS-2:0], ge};
            r_dsr <= r_dsr >> 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

// ===== rtl/vu_meter_needle_with_peak_hold_unit.sv =====
// Top level of the VU needle with peak hold: sequencer, tick scan and peak state.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  in       | sink      | i_in_valid / o_in_stall    | i_level
//  out      | source    | o_out_valid / i_out_stall  | o_needle_position, o_vu_frame,
//           |           |                            | o_peak_frame
//  cfg      | sink      | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
//  One beat in runs through level times gain, a scan over the ticks (up to 12),
//  then two multiply/divide pairs for the segment interpolation and for the frame
//  scaling. The one-bit-per-cycle shared multiplier and divider set the pace; a
//  level past the last tick skips one pair.
//  Reset (synchronous, active low) clears the sequencer, the output valid, the peak
//  state and loads the register defaults. A stalled output holds its beat while the
//  next input beat is taken and worked on; the new result waits in the done state.
module vu_meter_needle_with_peak_hold_unit #(
    parameter int LEVEL_FRACTION_BITS = 22
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [vumn_pkg::LEVEL_W-1:0]  i_level,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [vumn_pkg::POS_W-1:0]           o_needle_position,
    output logic [vumn_pkg::FRAME_W-1:0]         o_vu_frame,
    output logic [vumn_pkg::FRAME_W-1:0]         o_peak_frame,
    input  logic                                 i_cfg_we,
    input  logic [vumn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vumn_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import vumn_pkg::*;

    // Fraction bits of level * gain, and the shift that aligns it with the ROM.
    localparam int FRAC_ALL = LEVEL_FRACTION_BITS + GAIN_FRAC;
    localparam int XSH      = (FRAC_ALL < THR_W) ? (THR_W - FRAC_ALL) : 0;
    localparam int TSH      = (FRAC_ALL >= THR_W) ? (FRAC_ALL - THR_W) : 0;
    localparam int XRW      = MAG_W + GAIN_W;
    localparam int DW       = THR_W + TSH;
    localparam int CW       = ((XRW + XSH) > DW) ? (XRW + XSH) : DW;
    localparam int MPW      = DW + GAIN_W;
    localparam int NW       = DW + Q_BITS;
    localparam int MNBW     = $clog2(GAIN_W + 1);

    localparam logic [TICK_IW-1:0] LAST_IDX = TICK_IW'(TICK_COUNT - 1);

    // Configuration registers.
    logic [GAIN_W-1:0] r_gain;
    logic [DFR_W-1:0]  r_dframes;
    logic [HOLD_W-1:0] r_hold_upd;

    // Sequencer and peak state.
    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    logic [FRAME_W-1:0] r_held;
    logic [HOLD_W-1:0]  r_cd;

    // Working registers.
    logic [CW-1:0]      r_x;
    logic [TICK_IW-1:0] r_idx;
    logic [DW-1:0]      r_num;
    logic [DW-1:0]      r_den;
    logic [POS_W-1:0]   r_seg_span;
    logic [POS_W-1:0]   r_plo;
    logic [POS_W-1:0]   r_pos;
    logic [FRAME_W-1:0] r_frame;
    logic [POS_W-1:0]   r_out_pos;
    logic [FRAME_W-1:0] r_out_vu;
    logic [FRAME_W-1:0] r_out_peak;

    // Shared unit hookup.
    logic               mul_start;
    logic [DW-1:0]      mul_a;
    logic [GAIN_W-1:0]  mul_b;
    logic [MNBW-1:0]    mul_nbits;
    t_unit_stat         mul_stat;
    logic [MPW-1:0]     mul_prod;
    logic               div_start;
    logic [NW-1:0]      div_num;
    logic [DW-1:0]      div_den;
    t_unit_stat         div_stat;
    logic [Q_BITS-1:0]  div_quot;

    logic               in_acc;
    logic               out_free;
    logic               peak_load;
    logic [MAG_W-1:0]   mag;
    logic [FRAME_W-1:0] span;
    logic [CW-1:0]      thr_hi;
    logic [CW-1:0]      thr_lo;
    logic               x_lt;
    logic [TICK_IW-1:0] idx_m1;
    logic [FRAME_W-1:0] frame_q;
    logic [FRAME_W-1:0] held_nx;
    logic [FRAME_W-1:0] peak_nx;

    vumn_mul #(
        .AW (DW),
        .BW (GAIN_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .i_nbits   (mul_nbits),
        .o_stat    (mul_stat),
        .o_product (mul_prod)
    );

    vumn_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Clamp negative levels to zero.
    assign mag = i_level[LEVEL_W-1] ? '0 : i_level[MAG_W-1:0];

    // Frames minus one, with zero and one frame giving zero and anything past 256
    // treated as 256.
    always_comb begin
        if (r_dframes == '0) begin
            span = '0;
        end else if (r_dframes[DFR_W-1]) begin
            span = '1;
        end else begin
            span = FRAME_W'(r_dframes - 1'b1);
        end
    end

    // Thresholds aligned to the fraction point of r_x.
    assign idx_m1 = r_idx - 1'b1;
    assign thr_hi = CW'(tick_amp(r_idx)) << TSH;
    assign thr_lo = (r_idx == '0) ? '0 : (CW'(tick_amp(idx_m1)) << TSH);
    assign x_lt   = (r_x < thr_hi);

    assign frame_q = (div_quot > span) ? span : div_quot;

    // Peak hold: jump up at once, count down the hold, then follow.
    assign peak_load = (r_state == S_DONE) && out_free;
    always_comb begin
        if (r_frame > r_held) begin
            held_nx = r_frame;
        end else if (r_cd != '0) begin
            held_nx = r_held;
        end else begin
            held_nx = r_frame;
        end
        peak_nx = (held_nx > span) ? span : held_nx;
    end

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= GAIN_RST;
            r_dframes  <= DFR_RST;
            r_hold_upd <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INPUT_GAIN:     r_gain     <= i_cfg_data[GAIN_W-1:0];
                REG_DISPLAY_FRAMES: r_dframes  <= i_cfg_data[DFR_W-1:0];
                REG_HOLD_UPDATES:   r_hold_upd <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_cd        <= '0;
        end else begin
            r_state <= n_state;
            if (peak_load) begin
                r_out_valid <= 1'b1;
                r_held      <= held_nx;
                if (r_frame > r_held) begin
                    r_cd <= r_hold_upd;
                end else if (r_cd != '0) begin
                    r_cd <= r_cd - 1'b1;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sequencer: pick the next step and issue the shared-unit starts.
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_nbits = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    mul_start = 1'b1;
                    mul_a     = DW'(mag);
                    mul_b     = r_gain;
                    mul_nbits = MNBW'(GAIN_W);
                    n_state   = S_MUL_X;
                end
            end
            S_MUL_X: begin
                if (mul_stat.done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (x_lt) begin
                    n_state = S_SEG;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_FRM_GO;
                end
            end
            S_SEG: begin
                n_state = S_SEG_GO;
            end
            S_SEG_GO: begin
                mul_start = 1'b1;
                mul_a     = r_num;
                mul_b     = GAIN_W'(r_seg_span);
                mul_nbits = MNBW'(POS_W);
                n_state   = S_MUL_S;
            end
            S_MUL_S: begin
                if (mul_stat.done) begin
                    div_start = 1'b1;
                    div_num   = mul_prod[NW-1:0];
                    div_den   = r_den;
                    n_state   = S_DIV_S;
                end
            end
            S_DIV_S: begin
                if (div_stat.done) begin
                    n_state = S_FRM_GO;
                end
            end
            S_FRM_GO: begin
                mul_start = 1'b1;
                mul_a     = DW'(r_pos);
                mul_b     = GAIN_W'(span);
                mul_nbits = MNBW'(FRAME_W);
                n_state   = S_MUL_F;
            end
            S_MUL_F: begin
                if (mul_stat.done) begin
                    div_start = 1'b1;
                    div_num   = mul_prod[NW-1:0];
                    div_den   = DW'(FULL_POS);
                    n_state   = S_DIV_F;
                end
            end
            S_DIV_F: begin
                if (div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Working datapath; no reset needed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL_X: begin
                if (mul_stat.done) begin
                    r_x   <= CW'(mul_prod[XRW-1:0]) << XSH;
                    r_idx <= '0;
                end
            end
            S_SCAN: begin
                if (!x_lt) begin
                    if (r_idx == LAST_IDX) begin
                        r_pos <= tick_pos(LAST_IDX);
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            S_SEG: begin
                // Segment below the first tick starts from zero.
                r_num      <= DW'(r_x - thr_lo);
                r_den      <= DW'(thr_hi - thr_lo);
                r_plo      <= (r_idx == '0) ? '0 : tick_pos(idx_m1);
                r_seg_span <= tick_pos(r_idx) - ((r_idx == '0) ? '0 : tick_pos(idx_m1));
            end
            S_DIV_S: begin
                if (div_stat.done) begin
                    r_pos <= r_plo + POS_W'(div_quot);
                end
            end
            S_DIV_F: begin
                if (div_stat.done) begin
                    r_frame <= frame_q;
                end
            end
            default: ;
        endcase
    end

    // Output beat registers.
    always_ff @(posedge i_clk) begin
        if (peak_load) begin
            r_out_pos  <= r_pos;
            r_out_vu   <= r_frame;
            r_out_peak <= peak_nx;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_needle_position = r_out_pos;
    assign o_vu_frame        = r_out_vu;
    assign o_peak_frame      = r_out_peak;

`ifndef ASSERT_OFF
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output beat raised outside the done state");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_needle_position <= FULL_POS))
        else $error("needle position past full deflection");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_vu_frame <= span) && (o_peak_frame <= span)))
        else $error("frame index past the last display frame");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");
`endif

endmodule

// ===== verif/vu_meter_needle_with_peak_hold_unit_tb.sv =====
// Self-checking testbench of the VU needle with peak hold: directed corners, then random traffic.
`timescale 1ns / 100ps

module vu_meter_needle_with_peak_hold_unit_tb;

    import vumn_pkg::*;

    localparam int LEVEL_FRAC = 22;
    // Alignment of level*gain against the Q0.32 tick thresholds.
    localparam int FRAC_TOTAL = LEVEL_FRAC + GAIN_FRAC;
    localparam int THR_SHIFT  = (FRAC_TOTAL >= THR_W) ? FRAC_TOTAL - THR_W : 0;
    localparam int X_SHIFT    = (FRAC_TOTAL < THR_W) ? THR_W - FRAC_TOTAL : 0;
    localparam int FULL_SCALE = 129;
    localparam int IDLE_LIMIT = 5000;
    localparam int BEATS_PER_PHASE = 110;
    localparam int RANDOM_PHASES   = 8;

    // No register lives at this index; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [FRAME_W-1:0] vu_frame;
        logic [FRAME_W-1:0] peak_frame;
    } t_needle_reading;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [LEVEL_W-1:0]   i_level = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [POS_W-1:0]            o_needle_position;
    logic [FRAME_W-1:0]          o_vu_frame;
    logic [FRAME_W-1:0]          o_peak_frame;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    vu_meter_needle_with_peak_hold_unit #(
        .LEVEL_FRACTION_BITS(LEVEL_FRAC)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_level           (i_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_needle_position (o_needle_position),
        .o_vu_frame        (o_vu_frame),
        .o_peak_frame      (o_peak_frame),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Tick scale: thresholds as unsigned Q0.32 amplitudes, and the needle position at each.
    logic [31:0] tick_q032 [0:TICK_COUNT-1] = '{
        32'd38633126,  32'd122168673, 32'd172567838, 32'd217250034,
        32'd273501591, 32'd306873831, 32'd344318102, 32'd386331265,
        32'd433470809, 32'd486362247, 32'd545707417, 32'd578042614
    };
    logic [7:0] tick_needle [0:TICK_COUNT-1] = '{
        8'd4, 8'd21, 8'd32, 8'd42, 8'd56, 8'd65, 8'd74, 8'd84, 8'd97, 8'd109, 8'd123, 8'd129
    };

    // Mirror of the block's registers and peak state.
    logic [GAIN_W-1:0]  cal_gain    = GAIN_RST;
    logic [DFR_W-1:0]   frame_count = DFR_RST;
    logic [HOLD_W-1:0]  hold_len    = HOLD_RST;
    logic [FRAME_W-1:0] peak_held   = '0;
    logic [HOLD_W-1:0]  peak_timer  = '0;

    t_needle_reading readings_due [$];

    int fault_count     = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;
    int holdoff_request = 0;
    int holdoff_left    = 0;
    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_phase     = 0;
    int level_beats     = 0;

    // ------------------------------------------------------------------
    // Level to needle position
    // ------------------------------------------------------------------
    function automatic logic [63:0] tick_threshold(input int k);
        return 64'(tick_q032[k]) << THR_SHIFT;
    endfunction

    function automatic logic [POS_W-1:0] needle_from_level(input logic signed [LEVEL_W-1:0] lvl);
        logic [63:0] mag;
        logic [63:0] x;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] rise;
        int k;
        // Negative levels clamp to zero.
        mag = lvl[LEVEL_W-1] ? 64'd0 : 64'(lvl[LEVEL_W-2:0]);
        x = (mag * 64'(cal_gain)) << X_SHIFT;
        // Below the first tick: linear from zero.
        if (x < tick_threshold(0))
            return POS_W'((x * 64'(tick_needle[0])) / tick_threshold(0));
        for (k = 1; k < TICK_COUNT; k++) begin
            hi = tick_threshold(k);
            if (x < hi) begin
                lo = tick_threshold(k - 1);
                rise = 64'(tick_needle[k] - tick_needle[k - 1]);
                return POS_W'(64'(tick_needle[k - 1]) + ((x - lo) * rise) / (hi - lo));
            end
        end
        // Past the last tick: pin at full deflection.
        return tick_needle[TICK_COUNT - 1];
    endfunction

    // Work out the reading for one accepted level and queue it.
    task automatic advance_meter(input logic signed [LEVEL_W-1:0] lvl);
        t_needle_reading r;
        int span;
        int frame;
        r.position = needle_from_level(lvl);
        if (frame_count > 256)
            span = 255;
        else if (frame_count == 0)
            span = 0;
        else
            span = int'(frame_count) - 1;
        frame = (int'(r.position) * span) / FULL_SCALE;
        if (frame > span)
            frame = span;
        // Peak needle: jump up at once, hold, then follow.
        if (frame > int'(peak_held)) begin
            peak_held = FRAME_W'(frame);
            peak_timer = hold_len;
        end else if (peak_timer != 0) begin
            peak_timer = peak_timer - 1'b1;
        end else begin
            peak_held = FRAME_W'(frame);
        end
        r.vu_frame = FRAME_W'(frame);
        r.peak_frame = (int'(peak_held) > span) ? FRAME_W'(span) : peak_held;
        readings_due.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Level stimulus
    // ------------------------------------------------------------------
    // Smallest level whose product with the gain reaches the given amplitude.
    function automatic logic signed [LEVEL_W-1:0] level_for_x(input logic [63:0] target);
        logic [63:0] q;
        if (cal_gain == 0)
            return LEVEL_W'($urandom & 32'h007F_FFFF);
        q = ((target >> X_SHIFT) + 64'(cal_gain) - 1) / 64'(cal_gain);
        if (q > 64'h7F_FFFF)
            q = 64'h7F_FFFF;
        return q[LEVEL_W-1:0];
    endfunction

    function automatic logic signed [LEVEL_W-1:0] pick_level();
        logic [63:0] top;
        logic [63:0] r;
        int k;
        case ($urandom_range(0, 9))
            0: return {1'b1, 23'($urandom)};
            1: return LEVEL_W'($urandom);
            2: begin
                // Straddle a tick threshold.
                k = $urandom_range(0, TICK_COUNT - 1);
                return level_for_x(tick_threshold(k)) - LEVEL_W'($urandom_range(0, 1));
            end
            default: begin
                // Spread over the whole scale at the present gain.
                top = tick_threshold(TICK_COUNT - 1) + tick_threshold(TICK_COUNT - 1) / 8;
                r = {$urandom, $urandom};
                return level_for_x(r % top);
            end
        endcase
    endfunction

    // Offer one beat, wait for the handshake, predict its reading.
    task automatic send_level(input logic signed [LEVEL_W-1:0] lvl);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 4);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_level = lvl;
        do @(posedge i_clk); while (o_in_stall);
        advance_meter(lvl);
        burst_left--;
        level_beats++;
    endtask

    // A decaying run of levels: lets the peak needle rise, hold and fall back.
    task automatic send_decay(input int len);
        logic signed [LEVEL_W-1:0] lvl;
        int n;
        lvl = pick_level();
        for (n = 0; n < len; n++) begin
            send_level(lvl);
            if ($urandom_range(0, 7) == 0 || lvl[LEVEL_W-1])
                lvl = pick_level();
            else
                lvl = lvl - (lvl >>> $urandom_range(2, 5)) - LEVEL_W'($urandom_range(0, 3));
        end
    endtask

    // Drop valid and wait until every reading has come back.
    task automatic settle_meter();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Register write on an idle block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle_meter();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            REG_INPUT_GAIN:     cal_gain = data;
            REG_DISPLAY_FRAMES: frame_count = data[DFR_W-1:0];
            REG_HOLD_UPDATES:   hold_len = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: zero, signs, full scale and a few tick boundaries.
    task automatic test_scale_points();
        send_level('0);
        send_level(LEVEL_W'(1));
        send_level(-LEVEL_W'(1));
        send_level({1'b1, 23'd0});
        send_level({1'b0, {23{1'b1}}});
        send_level(LEVEL_W'(24'h40_0000));
        send_level(level_for_x(tick_threshold(0)) - 1'b1);
        send_level(level_for_x(tick_threshold(0)));
        send_level(level_for_x(tick_threshold(5)) - 1'b1);
        send_level(level_for_x(tick_threshold(5)));
        send_level(level_for_x(tick_threshold(TICK_COUNT - 1)) - 1'b1);
        send_level(level_for_x(tick_threshold(TICK_COUNT - 1)));
    endtask

    // Frame counts below two, above 256, and a shrink under a held peak.
    task automatic test_frame_counts();
        write_reg(REG_DISPLAY_FRAMES, 16'd0);
        send_level({1'b0, {23{1'b1}}});
        write_reg(REG_DISPLAY_FRAMES, 16'd1);
        send_level({1'b0, {23{1'b1}}});
        write_reg(REG_DISPLAY_FRAMES, 16'd511);
        send_level({1'b0, {23{1'b1}}});
        // Held peak now above the new top frame: must clamp.
        write_reg(REG_DISPLAY_FRAMES, 16'd2);
        send_level('0);
        write_reg(REG_DISPLAY_FRAMES, 16'd300);
        send_level(LEVEL_W'(200000));
        write_reg(REG_DISPLAY_FRAMES, 16'd256);
        send_level('0);
    endtask

    // Gain extremes and a write to an unused index.
    task automatic test_gain_and_spare_index();
        write_reg(REG_INPUT_GAIN, 16'd0);
        send_level({1'b0, {23{1'b1}}});
        write_reg(REG_INPUT_GAIN, 16'hFFFF);
        send_level(LEVEL_W'(10000));
        write_reg(REG_SPARE, 16'hFFFF);
        send_level(LEVEL_W'(2000));
        write_reg(REG_INPUT_GAIN, 16'd1);
        send_level({1'b0, {23{1'b1}}});
    endtask

    // Peak hold at zero, short and maximal hold lengths.
    task automatic test_peak_hold();
        logic [HOLD_W-1:0] lens [0:3];
        int n;
        lens = '{16'd0, 16'd1, 16'd3, 16'hFFFF};
        write_reg(REG_INPUT_GAIN, GAIN_RST);
        write_reg(REG_DISPLAY_FRAMES, 16'(DFR_RST));
        for (n = 0; n < 4; n++) begin
            write_reg(REG_HOLD_UPDATES, lens[n]);
            send_level(level_for_x(tick_threshold(TICK_COUNT - 1)));
            send_decay(12);
        end
    endtask

    // Hold the output off for a long stretch while levels keep coming.
    task automatic test_backpressure();
        int n;
        write_reg(REG_HOLD_UPDATES, HOLD_RST);
        @(posedge i_clk);
        holdoff_request = 800;
        for (n = 0; n < 24; n++)
            send_level(pick_level());
    endtask

    // Random settings per phase, mostly decaying runs with some noise.
    task automatic test_random_traffic();
        int p;
        int start;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(REG_INPUT_GAIN, 16'hFFFF);
                    write_reg(REG_DISPLAY_FRAMES, 16'd256);
                    write_reg(REG_HOLD_UPDATES, 16'hFFFF);
                end
                1: begin
                    write_reg(REG_INPUT_GAIN, 16'd1);
                    write_reg(REG_DISPLAY_FRAMES, 16'd2);
                    write_reg(REG_HOLD_UPDATES, 16'd0);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       write_reg(REG_INPUT_GAIN, 16'($urandom));
                        1:       write_reg(REG_INPUT_GAIN, GAIN_RST);
                        default: write_reg(REG_INPUT_GAIN, 16'($urandom_range(2048, 12000)));
                    endcase
                    if ($urandom_range(0, 9) < 7)
                        write_reg(REG_DISPLAY_FRAMES, 16'($urandom_range(2, 256)));
                    else
                        write_reg(REG_DISPLAY_FRAMES, 16'($urandom));
                    case ($urandom_range(0, 4))
                        0:       write_reg(REG_HOLD_UPDATES, 16'd0);
                        1:       write_reg(REG_HOLD_UPDATES, 16'($urandom_range(1, 3)));
                        2:       write_reg(REG_HOLD_UPDATES, 16'($urandom));
                        default: write_reg(REG_HOLD_UPDATES, 16'($urandom_range(0, 40)));
                    endcase
                end
            endcase
            start = level_beats;
            while (level_beats - start < BEATS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 7)
                    send_decay($urandom_range(4, 30));
                else
                    send_level(pick_level());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall patterns, each kept for a randomly drawn stretch,
    // plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (holdoff_request != 0) begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            i_out_stall = 1'b1;
        end else begin
            if (stall_mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_mode_left = $urandom_range(20, 300);
            end
            stall_mode_left--;
            stall_phase++;
            case (stall_mode)
                0:       i_out_stall = 1'b0;
                1:       i_out_stall = ($urandom_range(0, 4) == 0);
                2:       i_out_stall = ($urandom_range(0, 3) != 0);
                default: i_out_stall = ((stall_phase % 7) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each output beat with the oldest queued reading.
    // ------------------------------------------------------------------
    task automatic report_fault(input string field, input logic [7:0] got, input logic [7:0] want);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_needle_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (readings_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected beat at %0t: position %0d vu %0d peak %0d",
                             $realtime, o_needle_position, o_vu_frame, o_peak_frame);
            end else begin
                want = readings_due.pop_front();
                if (o_needle_position !== want.position)
                    report_fault("needle_position", o_needle_position, want.position);
                if (o_vu_frame !== want.vu_frame)
                    report_fault("vu_frame", o_vu_frame, want.vu_frame);
                if (o_peak_frame !== want.peak_frame)
                    report_fault("peak_frame", o_peak_frame, want.peak_frame);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_scale_points();
        test_frame_counts();
        test_gain_and_spare_index();
        test_peak_hold();
        test_backpressure();
        test_random_traffic();

        // Drain, then give stray beats a chance to show up.
        settle_meter();
        repeat (100) @(posedge i_clk);
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
